>>> hw/rtl/srcad_pkg.sv
package srcad_pkg;

  localparam int CB = 16;               // COORD_BITS

  // magnitude of the widest dividend: (start + quotient) * cropped extent
  localparam int DIV_W    = 3 * CB + 2;
  localparam int DIV_IN_W = DIV_W + 1;  // signed dividend
  localparam int SUM_W    = 2 * CB + 2; // start + first quotient, signed
  localparam int EXT_W    = CB + 2;     // cropped extent, signed

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 64;

  localparam logic [CFG_IDX_W-1:0] REG_SRC_ORIGIN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_SPAN     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DST_SIZE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_SIZE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CROP_MARGINS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ROTATION     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TRANSPOSED   = 3'd6;

  localparam logic [1:0] ROT_0   = 2'd0;
  localparam logic [1:0] ROT_90  = 2'd1;
  localparam logic [1:0] ROT_180 = 2'd2;
  localparam logic [1:0] ROT_270 = 2'd3;

  typedef struct packed {
    logic [15:0] dst_col;
    logic [15:0] dst_row;
  } in_item_t;

  typedef struct packed {
    logic [15:0] src_col;
    logic [15:0] src_row;
    logic        inside_res;
  } out_item_t;

  typedef struct packed {
    logic en;
    logic valid;
  } pipe_ctl_t;

endpackage

>>> hw/rtl/scale_rotate_crop_source_address.sv
// Channel | Direction | Handshake           | Payload
// in_     | input     | in_valid / in_stall | in_data  (dst_col, dst_row)
// out_    | output    | out_valid/out_stall | out_data (src_col, src_row, inside_res)
// cfg_    | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One item per clock while the output is not stalled. Pipeline: input multiply stage,
// two dividers in series (input register, 50 one-bit quotient stages, output register;
// by window/dest size then image size), the scale multiply stage between them,
// and the crop/rotate output stage.
// Reset is synchronous; it clears valid bits and config to defaults.
// A stall on a valid output freezes the whole pipeline; in_stall follows it.
module scale_rotate_crop_source_address (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  srcad_pkg::in_item_t                  in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output srcad_pkg::out_item_t                 out_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [srcad_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [srcad_pkg::CFG_DAT_W-1:0]      cfg_data
);

  localparam int CB = srcad_pkg::CB;

  logic [31:0] src_origin_r, src_span_r, dst_size_r, image_size_r;
  logic [63:0] crop_margins_r;
  logic [1:0]  rotation_r;
  logic        transposed_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_origin_r   <= '0;
      src_span_r     <= '0;
      dst_size_r     <= 32'h0001_0001;
      image_size_r   <= 32'h0001_0001;
      crop_margins_r <= '0;
      rotation_r     <= srcad_pkg::ROT_0;
      transposed_r   <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        srcad_pkg::REG_SRC_ORIGIN:   src_origin_r   <= cfg_data[31:0];
        srcad_pkg::REG_SRC_SPAN:     src_span_r     <= cfg_data[31:0];
        srcad_pkg::REG_DST_SIZE:     dst_size_r     <= cfg_data[31:0];
        srcad_pkg::REG_IMAGE_SIZE:   image_size_r   <= cfg_data[31:0];
        srcad_pkg::REG_CROP_MARGINS: crop_margins_r <= cfg_data;
        srcad_pkg::REG_ROTATION:     rotation_r     <= cfg_data[1:0];
        srcad_pkg::REG_TRANSPOSED:   transposed_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // config fields, low CB bits of each 16-bit slot
  logic signed [CB-1:0] sx, sy;
  logic [CB-1:0] scx, scy, dcx, dcy, iw, ih, cl, cr, ct, cb;
  assign sx  = $signed(src_origin_r[0 +: CB]);
  assign sy  = $signed(src_origin_r[16 +: CB]);
  assign scx = src_span_r[0 +: CB];
  assign scy = src_span_r[16 +: CB];
  assign dcx = dst_size_r[0 +: CB];
  assign dcy = dst_size_r[16 +: CB];
  assign iw  = image_size_r[0 +: CB];
  assign ih  = image_size_r[16 +: CB];
  assign cl  = crop_margins_r[0 +: CB];
  assign cr  = crop_margins_r[16 +: CB];
  assign ct  = crop_margins_r[32 +: CB];
  assign cb  = crop_margins_r[48 +: CB];

  logic signed [srcad_pkg::EXT_W-1:0] w_s, h_s, cw_s, ch_s;
  assign w_s = $signed({2'b00, iw}) - $signed({2'b00, cl}) - $signed({2'b00, cr});
  assign h_s = $signed({2'b00, ih}) - $signed({2'b00, ct}) - $signed({2'b00, cb});
  assign cw_s = (rotation_r == srcad_pkg::ROT_0 || rotation_r == srcad_pkg::ROT_180)
                ? w_s : h_s;
  assign ch_s = (rotation_r == srcad_pkg::ROT_0 || rotation_r == srcad_pkg::ROT_180)
                ? h_s : w_s;

  logic zero_size;
  assign zero_size = (dcx == '0) || (dcy == '0) || (iw == '0) || (ih == '0);

  // whole pipeline advances together
  logic                 en;
  logic                 out_valid_r;
  srcad_pkg::pipe_ctl_t ctl_a, ctl_b;
  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  // stage A: window products
  logic [2*CB-1:0]                     px_nxt;
  logic signed [srcad_pkg::EXT_W-1:0]  ny_nxt;
  logic signed [srcad_pkg::EXT_W+CB:0] py_nxt;
  logic signed [srcad_pkg::DIV_IN_W-1:0] dvx_r, dvy_r;
  logic                                  va_r;

  assign px_nxt = in_data.dst_col[CB-1:0] * scx;
  assign ny_nxt = transposed_r
                  ? $signed({2'b00, dcy}) - $signed({2'b00, in_data.dst_row[CB-1:0]})
                    - $signed(srcad_pkg::EXT_W'(1))
                  : $signed({2'b00, in_data.dst_row[CB-1:0]});
  assign py_nxt = ny_nxt * $signed({1'b0, scy});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (en) begin
      va_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dvx_r <= $signed({{(srcad_pkg::DIV_IN_W-2*CB){1'b0}}, px_nxt});
      dvy_r <= srcad_pkg::DIV_IN_W'(py_nxt);
    end
  end

  assign ctl_a = '{en: en, valid: va_r};

  logic                                  vq1_x, vq1_y;
  logic signed [srcad_pkg::DIV_IN_W-1:0] q1x, q1y;

  srcad_div u_div_wx (
    .clk, .rst_n, .ctl(ctl_a), .in_dividend(dvx_r), .in_divisor(dcx),
    .out_valid(vq1_x), .out_quotient(q1x)
  );

  srcad_div u_div_wy (
    .clk, .rst_n, .ctl(ctl_a), .in_dividend(dvy_r), .in_divisor(dcy),
    .out_valid(vq1_y), .out_quotient(q1y)
  );

  // stage B: offset by window start, scale by cropped extent
  logic signed [srcad_pkg::SUM_W-1:0]          sumx, sumy;
  logic signed [srcad_pkg::SUM_W+srcad_pkg::EXT_W-1:0] sclx, scly;
  logic signed [srcad_pkg::DIV_IN_W-1:0]       dsx_r, dsy_r;
  logic                                        vb_r;

  assign sumx = srcad_pkg::SUM_W'(sx) + q1x[srcad_pkg::SUM_W-1:0];
  assign sumy = srcad_pkg::SUM_W'(sy) + q1y[srcad_pkg::SUM_W-1:0];
  assign sclx = sumx * w_s;
  assign scly = sumy * h_s;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else if (en) begin
      vb_r <= vq1_x & vq1_y;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dsx_r <= srcad_pkg::DIV_IN_W'(sclx);
      dsy_r <= srcad_pkg::DIV_IN_W'(scly);
    end
  end

  assign ctl_b = '{en: en, valid: vb_r};

  logic                                  vq2_x, vq2_y;
  logic signed [srcad_pkg::DIV_IN_W-1:0] xp, yp;

  srcad_div u_div_ix (
    .clk, .rst_n, .ctl(ctl_b), .in_dividend(dsx_r), .in_divisor(iw),
    .out_valid(vq2_x), .out_quotient(xp)
  );

  srcad_div u_div_iy (
    .clk, .rst_n, .ctl(ctl_b), .in_dividend(dsy_r), .in_divisor(ih),
    .out_valid(vq2_y), .out_quotient(yp)
  );

  // stage C: bounds, quarter turns, crop offsets
  logic             in_img;
  logic [CB-1:0]    xl, yl, cwl, chl, xi, yi;
  srcad_pkg::out_item_t out_r, out_nxt;

  assign in_img = !zero_size
                  && !xp[srcad_pkg::DIV_IN_W-1] && !yp[srcad_pkg::DIV_IN_W-1]
                  && (xp < srcad_pkg::DIV_IN_W'(cw_s))
                  && (yp < srcad_pkg::DIV_IN_W'(ch_s));
  assign xl  = xp[CB-1:0];
  assign yl  = yp[CB-1:0];
  assign cwl = cw_s[CB-1:0];
  assign chl = ch_s[CB-1:0];

  always_comb begin
    case (rotation_r)
      srcad_pkg::ROT_0: begin
        xi = xl;
        yi = yl;
      end
      srcad_pkg::ROT_90: begin
        xi = yl;
        yi = cwl - xl - CB'(1);
      end
      srcad_pkg::ROT_180: begin
        xi = cwl - xl - CB'(1);
        yi = chl - yl - CB'(1);
      end
      default: begin
        xi = chl - yl - CB'(1);
        yi = xl;
      end
    endcase
    out_nxt            = '0;
    out_nxt.inside_res = in_img;
    if (in_img) begin
      out_nxt.src_col = 16'(xi + cl);
      out_nxt.src_row = 16'(yi + ct);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vq2_x & vq2_y;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

>>> hw/rtl/srcad_div.sv
// Pipelined signed divide, truncating toward zero: one quotient bit per stage.
module srcad_div (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  srcad_pkg::pipe_ctl_t                  ctl,
  input  logic signed [srcad_pkg::DIV_IN_W-1:0] in_dividend,
  input  logic        [srcad_pkg::CB-1:0]       in_divisor,
  output logic                                  out_valid,
  output logic signed [srcad_pkg::DIV_IN_W-1:0] out_quotient
);

  logic [srcad_pkg::CB-1:0]    rem_r [0:srcad_pkg::DIV_W];
  logic [srcad_pkg::DIV_W-1:0] qd_r  [0:srcad_pkg::DIV_W];
  logic [srcad_pkg::CB-1:0]    dv_r  [0:srcad_pkg::DIV_W];
  logic                        neg_r [0:srcad_pkg::DIV_W];
  logic                        vld_r [0:srcad_pkg::DIV_W];

  logic signed [srcad_pkg::DIV_IN_W-1:0] quot_r;
  logic                                  qvld_r;
  logic signed [srcad_pkg::DIV_IN_W-1:0] mag_nxt;

  assign mag_nxt = in_dividend[srcad_pkg::DIV_IN_W-1] ? -in_dividend : in_dividend;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (ctl.en) begin
      vld_r[0] <= ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      rem_r[0] <= '0;
      qd_r[0]  <= mag_nxt[srcad_pkg::DIV_W-1:0];
      dv_r[0]  <= in_divisor;
      neg_r[0] <= in_dividend[srcad_pkg::DIV_IN_W-1];
    end
  end

  for (genvar i = 0; i < srcad_pkg::DIV_W; i++) begin : g_stage
    logic [srcad_pkg::CB:0]   trial;
    logic [srcad_pkg::CB:0]   diff;
    logic                     ge;
    logic [srcad_pkg::CB-1:0] rem_nxt;

    assign trial   = {rem_r[i], qd_r[i][srcad_pkg::DIV_W-1]};
    assign diff    = trial - {1'b0, dv_r[i]};
    assign ge      = (trial >= {1'b0, dv_r[i]});
    assign rem_nxt = ge ? diff[srcad_pkg::CB-1:0] : trial[srcad_pkg::CB-1:0];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else if (ctl.en) begin
        vld_r[i+1] <= vld_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (ctl.en) begin
        rem_r[i+1] <= rem_nxt;
        qd_r[i+1]  <= {qd_r[i][srcad_pkg::DIV_W-2:0], ge};
        dv_r[i+1]  <= dv_r[i];
        neg_r[i+1] <= neg_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qvld_r <= 1'b0;
    end else if (ctl.en) begin
      qvld_r <= vld_r[srcad_pkg::DIV_W];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      if (neg_r[srcad_pkg::DIV_W]) begin
        quot_r <= -$signed({1'b0, qd_r[srcad_pkg::DIV_W]});
      end else begin
        quot_r <= $signed({1'b0, qd_r[srcad_pkg::DIV_W]});
      end
    end
  end

  assign out_valid    = qvld_r;
  assign out_quotient = quot_r;

endmodule
